### sv/marker_framed_packet_receiver_defines.svh
// Assertion macros used by the checker file of the receiver
`ifndef MARKER_FRAMED_PACKET_RECEIVER_DEFINES_SVH
`define MARKER_FRAMED_PACKET_RECEIVER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low
`define MFPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low
`define MFPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/mfpr_pkg.sv
package mfpr_pkg;

    // Packet store geometry
    localparam int STORE_DEPTH = 128;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int CMP_W       = (CNT_W > 9) ? CNT_W : 9;

    // Largest payload length accepted: keeps at most 31 words after a header
    localparam int LEN_LIMIT_I = (STORE_DEPTH - 4 > 127) ? 127 : STORE_DEPTH - 4;
    localparam logic [7:0] LEN_LIMIT = 8'(LEN_LIMIT_I);

    // CRC-8 and marker constants
    localparam logic [7:0] CRC_POLY     = 8'h07;
    localparam logic [7:0] CRC_INIT     = 8'h00;
    localparam logic [7:0] CRC_ALT      = 8'd111;
    localparam logic [7:0] FIRST_RESET  = 8'h10;
    localparam logic [7:0] SECOND_RESET = 8'h24;

    // Result kinds
    localparam logic [1:0] KIND_HDR  = 2'd0;
    localparam logic [1:0] KIND_WORD = 2'd1;
    localparam logic [1:0] KIND_CRC  = 2'd2;
    localparam logic [1:0] KIND_OVF  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SECOND = 2'd1;

    // Store write sources
    localparam logic [1:0] SRC_FIRST = 2'd0;
    localparam logic [1:0] SRC_RX    = 2'd1;
    localparam logic [1:0] SRC_HOLD  = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       wr_en;
        logic [1:0] wr_src;
        logic       pend_set;
        logic       pend_clr;
        logic       store_clr;
        logic       ptr_clr;
        logic       ptr_word;
        logic       rd_issue;
        logic       hdr_cap;
        logic       crc_clr;
        logic       crc_step;
        logic       word_shift;
        logic       out_load;
        logic [1:0] out_kind;
        logic       out_last;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic rx_first;
        logic rx_second;
        logic pending;
        logic store_empty;
        logic ovf;
        logic len_bad;
        logic crc_ok;
        logic hdr_done;
        logic crc_done;
        logic word_done;
        logic word_more;
        logic hdr_only;
        logic out_free;
    } dp_stat_t;

    // One byte through the CRC-8, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

### sv/marker_framed_packet_receiver.sv
// Plain bytes and markers: one byte per cycle while idle; a first marker followed by another byte
// holds s_ready low while both are stored. At a delimiter: 4 header reads, each with a capture,
// 1 check, a read and CRC step per payload byte, then reads again to emit each full payload word.
// All store reads share the single read port of the packet store; each read is followed by its use.
// Synchronous active-low reset restores the marker registers to 0x10 and 0x24 and empties
// the store; no clearing pass is run, store contents stay undefined until written.
module marker_framed_packet_receiver import mfpr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_client_id,
    output logic [7:0]  m_packet_type,
    output logic [7:0]  m_payload_length,
    output logic [7:0]  m_computed_crc,
    output logic [31:0] m_payload_word,
    output logic        m_last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Register writes are never stalled; each lands in the cycle after it is presented
    assign cfg_ready = 1'b1;

    mfpr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mfpr_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_rx_byte        (s_rx_byte),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_ready          (m_ready),
        .cmd              (cmd),
        .stat             (stat),
        .m_valid          (m_valid),
        .m_kind           (m_kind),
        .m_client_id      (m_client_id),
        .m_packet_type    (m_packet_type),
        .m_payload_length (m_payload_length),
        .m_computed_crc   (m_computed_crc),
        .m_payload_word   (m_payload_word),
        .m_last           (m_last)
    );

endmodule

### sv/mfpr_datapath.sv
module mfpr_datapath import mfpr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_rx_byte,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        m_ready,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output logic        m_valid,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_client_id,
    output logic [7:0]  m_packet_type,
    output logic [7:0]  m_payload_length,
    output logic [7:0]  m_computed_crc,
    output logic [31:0] m_payload_word,
    output logic        m_last
);

    logic [7:0]       first_marker_reg;
    logic [7:0]       second_marker_reg;
    logic             pending_reg;
    logic [CNT_W-1:0] count_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] ptr_reg;
    logic             m_valid_reg;

    logic [7:0]       mem [STORE_DEPTH];
    logic [7:0]       mem_q_reg;
    logic [1:0]       q_sel_reg;
    logic             q_keep_reg;
    logic [7:0]       hold_reg;
    logic [7:0]       cid_reg;
    logic [7:0]       typ_reg;
    logic [7:0]       rcrc_reg;
    logic [7:0]       len_reg;
    logic [7:0]       crc_reg;
    logic [31:0]      word_reg;

    logic [1:0]       m_kind_reg;
    logic [7:0]       m_cid_reg;
    logic [7:0]       m_typ_reg;
    logic [7:0]       m_len_reg;
    logic [7:0]       m_crc_reg;
    logic [31:0]      m_word_reg;
    logic             m_last_reg;

    logic             full;
    logic [7:0]       wr_data;
    logic [7:0]       rd_byte;
    logic [CMP_W-1:0] ptr_ext;
    logic [CMP_W-1:0] len_ext;

    assign full    = (count_reg == CNT_W'(STORE_DEPTH));
    assign rd_byte = q_keep_reg ? mem_q_reg : 8'h00;
    assign ptr_ext = CMP_W'(ptr_reg);
    assign len_ext = CMP_W'(len_reg);

    // Select the byte to store
    always_comb begin
        case (cmd.wr_src)
            SRC_FIRST: wr_data = first_marker_reg;
            SRC_RX:    wr_data = s_rx_byte;
            default:   wr_data = hold_reg;
        endcase
    end

    // Status towards the controller
    always_comb begin
        stat.rx_first    = (s_rx_byte == first_marker_reg);
        stat.rx_second   = (s_rx_byte == second_marker_reg);
        stat.pending     = pending_reg;
        stat.store_empty = (count_reg == '0) && !ovf_reg;
        stat.ovf         = ovf_reg;
        stat.len_bad     = (len_reg > LEN_LIMIT);
        stat.crc_ok      = (rcrc_reg == crc_reg) || ((crc_reg == 8'h00) && (rcrc_reg == CRC_ALT));
        stat.hdr_done    = (ptr_reg == CNT_W'(4));
        stat.crc_done    = (ptr_ext == len_ext + CMP_W'(4));
        stat.word_done   = (ptr_reg[1:0] == 2'd0);
        stat.word_more   = (ptr_ext <= len_ext);
        stat.hdr_only    = (len_reg < 8'd4);
        stat.out_free    = !m_valid_reg || m_ready;
    end

    // Packet store: one write port at the fill count, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.wr_en && !full) begin
            mem[count_reg[ADDR_W-1:0]] <= wr_data;
        end
        if (cmd.rd_issue) begin
            mem_q_reg <= mem[ptr_reg[ADDR_W-1:0]];
        end
    end

    // Control state: markers, pending flag, fill count, overflow, read pointer, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_marker_reg  <= FIRST_RESET;
            second_marker_reg <= SECOND_RESET;
            pending_reg       <= 1'b0;
            count_reg         <= '0;
            ovf_reg           <= 1'b0;
            ptr_reg           <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_FIRST:  first_marker_reg  <= cfg_data;
                    CFG_SECOND: second_marker_reg <= cfg_data;
                    default:    ;
                endcase
            end
            if (cmd.pend_set) begin
                pending_reg <= 1'b1;
            end else if (cmd.pend_clr) begin
                pending_reg <= 1'b0;
            end
            if (cmd.store_clr) begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end else if (cmd.wr_en) begin
                if (full) begin
                    ovf_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.ptr_clr) begin
                ptr_reg <= '0;
            end else if (cmd.ptr_word) begin
                ptr_reg <= CNT_W'(4);
            end else if (cmd.rd_issue) begin
                ptr_reg <= ptr_reg + CNT_W'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: held byte, read tags, header fields, CRC, word assembly, result register
    always_ff @(posedge aclk) begin
        if (cmd.wr_en && (cmd.wr_src == SRC_FIRST)) begin
            hold_reg <= s_rx_byte;
        end
        if (cmd.rd_issue) begin
            q_sel_reg  <= ptr_reg[1:0];
            q_keep_reg <= (ptr_reg < count_reg);
        end
        if (cmd.hdr_cap) begin
            case (q_sel_reg)
                2'd0:    cid_reg  <= rd_byte;
                2'd1:    typ_reg  <= rd_byte;
                2'd2:    rcrc_reg <= rd_byte;
                default: len_reg  <= rd_byte;
            endcase
        end
        if (cmd.crc_clr) begin
            crc_reg <= CRC_INIT;
        end else if (cmd.crc_step) begin
            crc_reg <= crc8_byte(crc_reg, rd_byte);
        end
        // shift in from the top so the first byte lands in the low lane
        if (cmd.word_shift) begin
            word_reg <= {rd_byte, word_reg[31:8]};
        end
        if (cmd.out_load) begin
            m_kind_reg <= cmd.out_kind;
            m_cid_reg  <= cid_reg;
            m_typ_reg  <= typ_reg;
            m_len_reg  <= len_reg;
            m_crc_reg  <= crc_reg;
            m_word_reg <= (cmd.out_kind == KIND_WORD) ? word_reg : 32'h0;
            m_last_reg <= cmd.out_last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = m_kind_reg;
    assign m_client_id      = m_cid_reg;
    assign m_packet_type    = m_typ_reg;
    assign m_payload_length = m_len_reg;
    assign m_computed_crc   = m_crc_reg;
    assign m_payload_word   = m_word_reg;
    assign m_last           = m_last_reg;

endmodule

### sv/mfpr_ctrl.sv
module mfpr_ctrl import mfpr_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_WR2      = 4'd1;
    localparam logic [3:0] ST_HDR_RD   = 4'd2;
    localparam logic [3:0] ST_HDR_USE  = 4'd3;
    localparam logic [3:0] ST_CHECK    = 4'd4;
    localparam logic [3:0] ST_CRC_LOOP = 4'd5;
    localparam logic [3:0] ST_CRC_USE  = 4'd6;
    localparam logic [3:0] ST_CRC_END  = 4'd7;
    localparam logic [3:0] ST_W_RD     = 4'd8;
    localparam logic [3:0] ST_W_USE    = 4'd9;
    localparam logic [3:0] ST_W_EMIT   = 4'd10;
    localparam logic [3:0] ST_ERR_EMIT = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Sequence: gather bytes, then read header, check, run CRC, walk words; overflow or bad length emits an error
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (stat.pending) begin
                        cmd.pend_clr = 1'b1;
                        if (stat.rx_second) begin
                            if (stat.store_empty) begin
                                cmd.store_clr = 1'b1;
                            end else begin
                                cmd.ptr_clr = 1'b1;
                                cmd.crc_clr = 1'b1;
                                state_next  = ST_HDR_RD;
                            end
                        end else begin
                            // store the held-back marker, then this byte
                            cmd.wr_en  = 1'b1;
                            cmd.wr_src = SRC_FIRST;
                            state_next = ST_WR2;
                        end
                    end else if (stat.rx_first) begin
                        cmd.pend_set = 1'b1;
                    end else begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_src = SRC_RX;
                    end
                end
            end
            ST_WR2: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = SRC_HOLD;
                state_next = ST_IDLE;
            end
            ST_HDR_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_HDR_USE;
            end
            ST_HDR_USE: begin
                cmd.hdr_cap = 1'b1;
                state_next  = stat.hdr_done ? ST_CHECK : ST_HDR_RD;
            end
            ST_CHECK: begin
                state_next = (stat.ovf || stat.len_bad) ? ST_ERR_EMIT : ST_CRC_LOOP;
            end
            ST_CRC_LOOP: begin
                if (stat.crc_done) begin
                    state_next = ST_CRC_END;
                end else begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_CRC_USE;
                end
            end
            ST_CRC_USE: begin
                cmd.crc_step = 1'b1;
                state_next   = ST_CRC_LOOP;
            end
            ST_CRC_END: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    if (!stat.crc_ok) begin
                        cmd.out_kind  = KIND_CRC;
                        cmd.out_last  = 1'b1;
                        cmd.store_clr = 1'b1;
                        state_next    = ST_IDLE;
                    end else if (stat.hdr_only) begin
                        cmd.out_kind  = KIND_HDR;
                        cmd.out_last  = 1'b1;
                        cmd.store_clr = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        cmd.out_kind = KIND_HDR;
                        cmd.ptr_word = 1'b1;
                        state_next   = ST_W_RD;
                    end
                end
            end
            ST_W_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_W_USE;
            end
            ST_W_USE: begin
                cmd.word_shift = 1'b1;
                state_next     = stat.word_done ? ST_W_EMIT : ST_W_RD;
            end
            ST_W_EMIT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_WORD;
                    cmd.out_last = !stat.word_more;
                    if (stat.word_more) begin
                        state_next = ST_W_RD;
                    end else begin
                        cmd.store_clr = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            ST_ERR_EMIT: begin
                if (stat.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_kind  = KIND_OVF;
                    cmd.out_last  = 1'b1;
                    cmd.store_clr = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/mfpr_checker.sv
`include "marker_framed_packet_receiver_defines.svh"

module mfpr_checker import mfpr_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_kind,
    input logic [7:0]  m_client_id,
    input logic [7:0]  m_packet_type,
    input logic [7:0]  m_payload_length,
    input logic [7:0]  m_computed_crc,
    input logic [31:0] m_payload_word,
    input logic        m_last
);

    // A stalled result keeps its kind, word, last flag and CRC until its transfer
    `MFPR_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_kind) && $stable(m_payload_word) && $stable(m_last) && $stable(m_computed_crc), "result changed while stalled")

    // Only payload words carry data in the word field
    `MFPR_ASSERT_NOW(a_word_zero, m_valid && (m_kind != KIND_WORD), m_payload_word == 32'h0, "non-word result carries a word")

    // Overflow and length errors end the run and carry no CRC
    `MFPR_ASSERT_NOW(a_ovf_last, m_valid && (m_kind == KIND_OVF), m_last && (m_computed_crc == 8'h00), "overflow result malformed")

    // A header that closes the run has no full word to follow
    `MFPR_ASSERT_NOW(a_hdr_last, m_valid && (m_kind == KIND_HDR) && m_last, m_payload_length < 8'd4, "header closed a run with words due")

    // A CRC mismatch is a single result
    `MFPR_ASSERT_NOW(a_crc_last, m_valid && (m_kind == KIND_CRC), m_last, "crc mismatch without last")

endmodule

bind marker_framed_packet_receiver mfpr_checker u_mfpr_checker (.*);
